>>> rtl/mac_learning_flow_controller_unit_assert.svh
// assertion macros included by the top-level rtl module
`ifndef MAC_LEARNING_FLOW_CONTROLLER_UNIT_ASSERT_SVH
`define MAC_LEARNING_FLOW_CONTROLLER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked implication checked outside reset
`define MLFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// clocked implication whose consequent is checked in the next cycle
`define MLFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MLFC_ASSERT_IMPL(label, ante, cons, msg)
`define MLFC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/mlfc_pkg.sv
package mlfc_pkg;

  localparam int SWITCH_COUNT = 4;

  localparam logic [15:0] PORT_FLOOD  = 16'd65531;
  localparam logic [15:0] PORT_UPLINK = 16'd0;
  localparam logic [31:0] NO_BUFFER   = 32'hFFFF_FFFF;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

  localparam int CFG_DATA_W = 16;

  typedef enum logic [0:0] {
    CFG_SWITCH_ENABLE  = 1'b0,
    CFG_EXPIRE_SECONDS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  switch_id;
    logic [15:0] in_port;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] held_buf;
  } in_word_t;

  typedef struct packed {
    logic [15:0] match_in_port;
    logic [47:0] match_src_mac;
    logic [47:0] match_dst_mac;
    logic [15:0] action_port;
    logic [31:0] rel_buf;
    logic [15:0] hard_timeout;
    logic        last;
  } out_word_t;

  // search token that walks the cell row
  typedef struct packed {
    logic        active;
    logic [1:0]  sw;
    logic [47:0] mac;
    logic        hit;
    logic [15:0] hit_port;
    logic        free;
  } tok_t;

  // table write broadcast to all cells
  typedef struct packed {
    logic        we;
    logic [1:0]  sw;
    logic [47:0] mac;
    logic [15:0] port;
  } wr_t;

endpackage

>>> rtl/mlfc_cell.sv
module mlfc_cell #(
  parameter int ENTRIES = 64,
  parameter int IDX     = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mlfc_pkg::tok_t             tok_in,
  input  logic [$clog2(ENTRIES)-1:0] hit_idx_in,
  input  logic [$clog2(ENTRIES)-1:0] free_idx_in,
  output mlfc_pkg::tok_t             tok_out,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_out,
  output logic [$clog2(ENTRIES)-1:0] free_idx_out,
  input  mlfc_pkg::wr_t              wr,
  input  logic [$clog2(ENTRIES)-1:0] wr_idx
);
  import mlfc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic              valid_r;
  logic [1:0]        sw_r;
  logic [47:0]       mac_r;
  logic [15:0]       port_r;
  tok_t              tok_r, tok_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic              wr_me;

  assign wr_me = wr.we && (wr_idx == MY_IDX);

  always_comb begin
    tok_nxt      = tok_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    if (tok_in.active) begin
      // first matching entry wins
      if (!tok_in.hit && valid_r && sw_r == tok_in.sw && mac_r == tok_in.mac) begin
        tok_nxt.hit      = 1'b1;
        tok_nxt.hit_port = port_r;
        hit_idx_nxt      = MY_IDX;
      end
      // lowest empty slot
      if (!tok_in.free && !valid_r) begin
        tok_nxt.free = 1'b1;
        free_idx_nxt = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_me) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (wr_me) begin
      sw_r   <= wr.sw;
      mac_r  <= wr.mac;
      port_r <= wr.port;
    end
  end

  assign tok_out      = tok_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;

endmodule

>>> rtl/mac_learning_flow_controller_unit.sv
// mac learning flow controller: takes one packet-in word on start && !busy and
// answers with one or two flow words on out_word, each shown for exactly one
// cycle under out_strobe; the receiver cannot stall, so it must take every
// word in the cycle it appears. the mac table lives in a row of TABLE_ENTRIES
// cells; a search token walks one cell per cycle, so an event that needs the
// table keeps busy high until the token leaves the last cell when it
// arrives on the uplink, and through the S_REV state as well when it arrives on
// another port (the learn write plus a second reverse-flow word). a broadcast
// word on the uplink skips the table and leaves busy low, one per cycle.
// events from a disabled switch are dropped with no result. the table starts
// empty after reset with no clearing pass; configuration is written through
// cfg_we/cfg_index/cfg_data, which the user must do while the block is idle; the block does not enforce it.
module mac_learning_flow_controller_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mlfc_pkg::in_word_t            in_word,
  output logic                          out_strobe,
  output mlfc_pkg::out_word_t           out_word,
  input  logic                          cfg_we,
  input  mlfc_pkg::cfg_index_t          cfg_index,
  input  logic [mlfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mlfc_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_REV    = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [3:0]       sw_en_r;
  logic [15:0]      expire_r;
  in_word_t         cur_r, cur_nxt;
  logic [IDX_W-1:0] rp_r, rp_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_word_t        out_r, out_nxt;

  // cell row plumbing
  tok_t             tok   [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] hidx  [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] fidx  [TABLE_ENTRIES+1];
  tok_t             tok_launch;
  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;
  tok_t             end_tok;

  logic accept, sw_ok, in_bcast, need_search, cur_bcast, cur_uplink;
  logic [15:0] fwd_act;

  assign accept  = start && (state_r == S_IDLE);
  assign sw_ok   = (32'(in_word.switch_id) < SWITCH_COUNT) && sw_en_r[in_word.switch_id];
  assign in_bcast = (in_word.dst_mac == MAC_BCAST);
  // only broadcast on the uplink can skip the table
  assign need_search = (in_word.in_port != PORT_UPLINK) || !in_bcast;

  assign cur_bcast  = (cur_r.dst_mac == MAC_BCAST);
  assign cur_uplink = (cur_r.in_port == PORT_UPLINK);
  assign end_tok    = tok[TABLE_ENTRIES];

  // launch token: key is the source mac when learning, else the destination
  always_comb begin
    tok_launch        = '0;
    tok_launch.active = accept && sw_ok && need_search;
    tok_launch.sw     = in_word.switch_id;
    tok_launch.mac    = (in_word.in_port != PORT_UPLINK) ? in_word.src_mac : in_word.dst_mac;
  end

  assign tok[0]  = tok_launch;
  assign hidx[0] = '0;
  assign fidx[0] = '0;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      mlfc_cell #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX     (g)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_in       (tok[g]),
        .hit_idx_in   (hidx[g]),
        .free_idx_in  (fidx[g]),
        .tok_out      (tok[g+1]),
        .hit_idx_out  (hidx[g+1]),
        .free_idx_out (fidx[g+1]),
        .wr           (wr),
        .wr_idx       (wr_idx)
      );
    end
  endgenerate

  // forward action once the search is back
  always_comb begin
    if (cur_bcast) begin
      fwd_act = cur_uplink ? PORT_FLOOD : PORT_UPLINK;
    end else if (!cur_uplink) begin
      fwd_act = PORT_UPLINK;
    end else begin
      fwd_act = end_tok.hit ? end_tok.hit_port : PORT_FLOOD;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    rp_nxt         = rp_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    wr             = '0;
    wr.sw          = cur_r.switch_id;
    wr.mac         = cur_r.src_mac;
    wr.port        = cur_r.in_port;
    wr_idx         = rp_r;

    case (state_r)
      S_IDLE: begin
        if (accept && sw_ok) begin
          cur_nxt = in_word;
          if (need_search) begin
            state_nxt = S_SEARCH;
          end else begin
            // uplink broadcast floods right away
            out_strobe_nxt        = 1'b1;
            out_nxt.match_in_port = in_word.in_port;
            out_nxt.match_src_mac = in_word.src_mac;
            out_nxt.match_dst_mac = in_word.dst_mac;
            out_nxt.action_port   = PORT_FLOOD;
            out_nxt.rel_buf       = in_word.held_buf;
            out_nxt.hard_timeout  = expire_r;
            out_nxt.last          = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (end_tok.active) begin
          out_strobe_nxt        = 1'b1;
          out_nxt.match_in_port = cur_r.in_port;
          out_nxt.match_src_mac = cur_r.src_mac;
          out_nxt.match_dst_mac = cur_r.dst_mac;
          out_nxt.action_port   = fwd_act;
          out_nxt.rel_buf       = cur_r.held_buf;
          out_nxt.hard_timeout  = expire_r;
          out_nxt.last          = cur_uplink;
          if (cur_uplink) begin
            state_nxt = S_IDLE;
          end else begin
            // learn: known entry, else lowest empty, else round robin victim
            wr.we = 1'b1;
            if (end_tok.hit) begin
              wr_idx = hidx[TABLE_ENTRIES];
            end else if (end_tok.free) begin
              wr_idx = fidx[TABLE_ENTRIES];
            end else begin
              wr_idx = rp_r;
              rp_nxt = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
            end
            state_nxt = S_REV;
          end
        end
      end
      S_REV: begin
        // reverse flow back toward the learned port
        out_strobe_nxt        = 1'b1;
        out_nxt.match_in_port = PORT_UPLINK;
        out_nxt.match_src_mac = cur_r.dst_mac;
        out_nxt.match_dst_mac = cur_r.src_mac;
        out_nxt.action_port   = cur_r.in_port;
        out_nxt.rel_buf       = NO_BUFFER;
        out_nxt.hard_timeout  = expire_r;
        out_nxt.last          = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sw_en_r      <= '0;
      expire_r     <= '0;
      rp_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rp_r         <= rp_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SWITCH_ENABLE:  sw_en_r  <= cfg_data[3:0];
          CFG_EXPIRE_SECONDS: expire_r <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  // checks
`include "mac_learning_flow_controller_unit_assert.svh"

  `MLFC_ASSERT_IMPL(a_tok_only_in_search, end_tok.active, state_r == S_SEARCH, "token outside search")
  `MLFC_ASSERT_IMPL(a_rev_after_fwd, state_r == S_REV, out_strobe && !out_word.last, "reverse without forward")
  `MLFC_ASSERT_NEXT(a_fwd_then_last, out_strobe && !out_word.last, out_strobe && out_word.last, "missing reverse word")

endmodule
